@@ sv/visibility_row_selection_filter_assert.svh @@
// Assertion macros used by the filter pipeline (vrsf_pipe).
`ifndef VISIBILITY_ROW_SELECTION_FILTER_ASSERT_SVH
`define VISIBILITY_ROW_SELECTION_FILTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VRSF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VRSF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/vrsf_pkg.sv @@
package vrsf_pkg;

    localparam int MAX_ID   = 32;
    localparam int MAP_W    = 32;

    localparam int ID_W     = 8;
    localparam int TIME_W   = 32;
    localparam int COORD_W  = 24;
    localparam int SQ_W     = 2 * COORD_W - 1;
    localparam int D2_W     = SQ_W + 1;
    localparam int BOUND_W  = 32;
    localparam int WIDE_W   = 64;
    localparam int ROW_W    = 32;
    localparam int MODE_W   = 11;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int TDATA_IN_W = 128;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANTENNA  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DATADESC = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCAN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STATE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TIME     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UV       = 3'd7;

    // Antenna modes
    localparam logic [1:0] ANT_OFF      = 2'd0;
    localparam logic [1:0] ANT_LIST     = 2'd1;
    localparam logic [1:0] ANT_NEGATED  = 2'd2;
    localparam logic [1:0] ANT_BASELINE = 2'd3;

    // Window modes
    localparam logic [1:0] WIN_OFF     = 2'd0;
    localparam logic [1:0] WIN_GREATER = 2'd1;
    localparam logic [1:0] WIN_LESS    = 2'd2;
    localparam logic [1:0] WIN_RANGE   = 2'd3;

    // Mode bit positions
    localparam int MODE_ANT_LSB   = 0;
    localparam int MODE_FIELD     = 2;
    localparam int MODE_DATADESC  = 3;
    localparam int MODE_SCAN      = 4;
    localparam int MODE_SCAN_NEG  = 5;
    localparam int MODE_STATE     = 6;
    localparam int MODE_TIME_LSB  = 7;
    localparam int MODE_UV_LSB    = 9;

    // Input item, last declared field (antenna_first) in the lowest bits
    typedef struct packed {
        logic signed [COORD_W-1:0] v_coord;
        logic signed [COORD_W-1:0] u_coord;
        logic [TIME_W-1:0]         row_time;
        logic [ID_W-1:0]           state_number;
        logic [ID_W-1:0]           scan_index;
        logic [ID_W-1:0]           datadesc_number;
        logic [ID_W-1:0]           field_number;
        logic [ID_W-1:0]           antenna_second;
        logic [ID_W-1:0]           antenna_first;
    } row_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [MAP_W-1:0]   antenna_mask;
        logic [MAP_W-1:0]   field_mask;
        logic [MAP_W-1:0]   datadesc_mask;
        logic [MAP_W-1:0]   scan_mask;
        logic [MAP_W-1:0]   state_mask;
        logic [BOUND_W-1:0] time_lo;
        logic [BOUND_W-1:0] time_hi;
        logic [WIDE_W-1:0]  uv_lo_sq;
        logic [WIDE_W-1:0]  uv_hi_sq;
    } cfg_t;

    // IDs past the bitmap never match
    function automatic logic id_hit(input logic [MAP_W-1:0] map, input logic [ID_W-1:0] id,
                                    input int limit);
        logic hit;
        hit = 1'b0;
        if (int'(id) < limit)
            hit = map[id[4:0]];
        return hit;
    endfunction

    function automatic logic window_pass(input logic [1:0] mode, input logic [WIDE_W-1:0] val,
                                         input logic [WIDE_W-1:0] lo,
                                         input logic [WIDE_W-1:0] hi);
        logic ok;
        unique case (mode)
            WIN_OFF:     ok = 1'b1;
            WIN_GREATER: ok = (val > lo);
            WIN_LESS:    ok = (val < hi);
            WIN_RANGE:   ok = (val >= lo) && (val <= hi);
        endcase
        return ok;
    endfunction

endpackage

@@ sv/visibility_row_selection_filter.sv @@
// Visibility row selection filter.
// Input stream (s_*): one visibility row per transfer, the fields packed in
// s_tdata. Output stream (m_*): one result per row, in order; m_tuser is the
// pass flag, m_tdata the row index since reset (wraps at 2^32).
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 mode, 1 antenna, 2 field, 3 datadesc, 4 scan, 5 state, 6 time, 7 uv).
// Write it only while no rows are in flight. The uv bounds are squared as
// they are written.
// Each row passes through three register stages on its way to m_*:
// input, match, result.
// Throughput: one row per cycle while m_tready stays high; the coordinate
// squares sit in the match stage, the uv sum and its compare in the result
// stage. A stalled output holds its result; empty stages still fill, so
// s_tready drops only when all three stages are full and m_tready is low.
// Reset clears the configuration, the valid flags and the row counter; the
// data registers are left as they are.
module visibility_row_selection_filter
#(
    parameter int MAX_ID = vrsf_pkg::MAX_ID
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // antenna_first, antenna_second, field_number, datadesc_number,
    // scan_index, state_number, row_time, u_coord, v_coord
    input  logic [vrsf_pkg::TDATA_IN_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // row_number
    output logic [vrsf_pkg::ROW_W-1:0]          m_tdata,
    // row_selected
    output logic                                m_tuser,
    input  logic                                cfg_we,
    input  logic [vrsf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vrsf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    vrsf_pkg::cfg_t cfg;
    vrsf_pkg::row_t in_row;

    assign in_row = vrsf_pkg::row_t'(s_tdata);

    vrsf_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    vrsf_pipe
    #(
        .MAX_ID (MAX_ID)
    )
    u_pipe
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_row       (in_row),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_selected (m_tuser),
        .out_number   (m_tdata)
    );

endmodule

@@ sv/vrsf_cfg.sv @@
module vrsf_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [vrsf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vrsf_pkg::CFG_DATA_W-1:0]     cfg_data,
    output vrsf_pkg::cfg_t                      cfg
);

    vrsf_pkg::cfg_t cfg_reg;
    logic [vrsf_pkg::BOUND_W-1:0] uv_lo_in;
    logic [vrsf_pkg::BOUND_W-1:0] uv_hi_in;
    logic [vrsf_pkg::WIDE_W-1:0]  uv_lo_sq_next;
    logic [vrsf_pkg::WIDE_W-1:0]  uv_hi_sq_next;

    // Square the uv bounds once, at write time
    assign uv_lo_in = cfg_data[31:0];
    assign uv_hi_in = cfg_data[63:32];
    assign uv_lo_sq_next = 64'(uv_lo_in) * 64'(uv_lo_in);
    assign uv_hi_sq_next = 64'(uv_hi_in) * 64'(uv_hi_in);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                vrsf_pkg::REG_MODE:     cfg_reg.mode <= cfg_data[vrsf_pkg::MODE_W-1:0];
                vrsf_pkg::REG_ANTENNA:  cfg_reg.antenna_mask <= cfg_data[31:0];
                vrsf_pkg::REG_FIELD:    cfg_reg.field_mask <= cfg_data[31:0];
                vrsf_pkg::REG_DATADESC: cfg_reg.datadesc_mask <= cfg_data[31:0];
                vrsf_pkg::REG_SCAN:     cfg_reg.scan_mask <= cfg_data[31:0];
                vrsf_pkg::REG_STATE:    cfg_reg.state_mask <= cfg_data[31:0];
                vrsf_pkg::REG_TIME:
                begin
                    cfg_reg.time_lo <= cfg_data[31:0];
                    cfg_reg.time_hi <= cfg_data[63:32];
                end
                vrsf_pkg::REG_UV:
                begin
                    cfg_reg.uv_lo_sq <= uv_lo_sq_next;
                    cfg_reg.uv_hi_sq <= uv_hi_sq_next;
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ sv/vrsf_pipe.sv @@
`include "visibility_row_selection_filter_assert.svh"

module vrsf_pipe
#(
    parameter int MAX_ID = vrsf_pkg::MAX_ID
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  vrsf_pkg::cfg_t                  cfg,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  vrsf_pkg::row_t                  in_row,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            out_selected,
    output logic [vrsf_pkg::ROW_W-1:0]      out_number
);

    localparam int ID_LIMIT = (MAX_ID < vrsf_pkg::MAP_W) ? MAX_ID : vrsf_pkg::MAP_W;

    logic                           a_valid_reg;
    vrsf_pkg::row_t                 a_row_reg;
    logic [vrsf_pkg::ROW_W-1:0]     a_num_reg;
    logic [vrsf_pkg::ROW_W-1:0]     row_counter_reg;

    logic                           b_valid_reg;
    logic                           b_pass_reg;
    logic [vrsf_pkg::SQ_W-1:0]      b_usq_reg;
    logic [vrsf_pkg::SQ_W-1:0]      b_vsq_reg;
    logic [vrsf_pkg::ROW_W-1:0]     b_num_reg;

    logic                           c_valid_reg;
    logic                           c_sel_reg;
    logic [vrsf_pkg::ROW_W-1:0]     c_num_reg;

    logic a_adv;
    logic b_adv;
    logic c_adv;
    logic in_xfer;

    logic [1:0]                     ant_mode;
    logic                           ant_ok;
    logic                           ant_any;
    logic                           base_ok;
    logic                           field_ok;
    logic                           dd_ok;
    logic                           scan_ok;
    logic                           scan_hit;
    logic                           state_ok;
    logic                           time_ok;
    logic                           b_pass_next;
    logic [vrsf_pkg::COORD_W-1:0]   u_abs;
    logic [vrsf_pkg::COORD_W-1:0]   v_abs;
    logic [vrsf_pkg::SQ_W-1:0]      b_usq_next;
    logic [vrsf_pkg::SQ_W-1:0]      b_vsq_next;
    logic [vrsf_pkg::D2_W-1:0]      d2;
    logic                           c_sel_next;

    // Each stage moves when it is empty or the stage after it moves
    assign c_adv   = !c_valid_reg || out_ready;
    assign b_adv   = !b_valid_reg || c_adv;
    assign a_adv   = !a_valid_reg || b_adv;
    assign in_ready = a_adv;
    assign in_xfer = in_valid && a_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_counter_reg <= '0;
            a_valid_reg     <= 1'b0;
            b_valid_reg     <= 1'b0;
            c_valid_reg     <= 1'b0;
        end
        else
        begin
            if (in_xfer)
                row_counter_reg <= row_counter_reg + 32'd1;
            if (a_adv)
                a_valid_reg <= in_valid;
            if (b_adv)
                b_valid_reg <= a_valid_reg;
            if (c_adv)
                c_valid_reg <= b_valid_reg;
        end
    end

    // Stage A: input register
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            a_row_reg <= in_row;
            a_num_reg <= row_counter_reg;
        end
    end

    // Stage B: ID tests, time window, coordinate squares
    always_comb
    begin
        ant_mode = cfg.mode[vrsf_pkg::MODE_ANT_LSB +: 2];
        ant_any  = vrsf_pkg::id_hit(cfg.antenna_mask, a_row_reg.antenna_first, ID_LIMIT) ||
                   vrsf_pkg::id_hit(cfg.antenna_mask, a_row_reg.antenna_second, ID_LIMIT);
        base_ok  = ((16'(a_row_reg.antenna_first) == cfg.antenna_mask[15:0]) &&
                    (16'(a_row_reg.antenna_second) == cfg.antenna_mask[31:16])) ||
                   ((16'(a_row_reg.antenna_first) == cfg.antenna_mask[31:16]) &&
                    (16'(a_row_reg.antenna_second) == cfg.antenna_mask[15:0]));
        unique case (ant_mode)
            vrsf_pkg::ANT_OFF:      ant_ok = 1'b1;
            vrsf_pkg::ANT_LIST:     ant_ok = ant_any;
            vrsf_pkg::ANT_NEGATED:  ant_ok = !ant_any;
            vrsf_pkg::ANT_BASELINE: ant_ok = base_ok;
        endcase

        field_ok = !cfg.mode[vrsf_pkg::MODE_FIELD] ||
                   vrsf_pkg::id_hit(cfg.field_mask, a_row_reg.field_number, ID_LIMIT);
        dd_ok    = !cfg.mode[vrsf_pkg::MODE_DATADESC] ||
                   vrsf_pkg::id_hit(cfg.datadesc_mask, a_row_reg.datadesc_number, ID_LIMIT);
        scan_hit = vrsf_pkg::id_hit(cfg.scan_mask, a_row_reg.scan_index, ID_LIMIT) ^
                   cfg.mode[vrsf_pkg::MODE_SCAN_NEG];
        scan_ok  = !cfg.mode[vrsf_pkg::MODE_SCAN] || scan_hit;
        state_ok = !cfg.mode[vrsf_pkg::MODE_STATE] ||
                   vrsf_pkg::id_hit(cfg.state_mask, a_row_reg.state_number, ID_LIMIT);
        time_ok  = vrsf_pkg::window_pass(cfg.mode[vrsf_pkg::MODE_TIME_LSB +: 2],
                                         64'(a_row_reg.row_time),
                                         64'(cfg.time_lo), 64'(cfg.time_hi));
        b_pass_next = ant_ok && field_ok && dd_ok && scan_ok && state_ok && time_ok;

        // Magnitude of the most negative coordinate still fits unsigned
        u_abs = a_row_reg.u_coord[vrsf_pkg::COORD_W-1] ? (~a_row_reg.u_coord + 24'd1)
                                                       : a_row_reg.u_coord;
        v_abs = a_row_reg.v_coord[vrsf_pkg::COORD_W-1] ? (~a_row_reg.v_coord + 24'd1)
                                                       : a_row_reg.v_coord;
    end

    assign b_usq_next = vrsf_pkg::SQ_W'(48'(u_abs) * 48'(u_abs));
    assign b_vsq_next = vrsf_pkg::SQ_W'(48'(v_abs) * 48'(v_abs));

    always_ff @(posedge clk)
    begin
        if (a_valid_reg && b_adv)
        begin
            b_pass_reg <= b_pass_next;
            b_usq_reg  <= b_usq_next;
            b_vsq_reg  <= b_vsq_next;
            b_num_reg  <= a_num_reg;
        end
    end

    // Stage C: uv distance window, result register
    assign d2 = vrsf_pkg::D2_W'(b_usq_reg) + vrsf_pkg::D2_W'(b_vsq_reg);
    assign c_sel_next = b_pass_reg &&
                        vrsf_pkg::window_pass(cfg.mode[vrsf_pkg::MODE_UV_LSB +: 2], 64'(d2),
                                              cfg.uv_lo_sq, cfg.uv_hi_sq);

    always_ff @(posedge clk)
    begin
        if (b_valid_reg && c_adv)
        begin
            c_sel_reg <= c_sel_next;
            c_num_reg <= b_num_reg;
        end
    end

    assign out_valid    = c_valid_reg;
    assign out_selected = c_sel_reg;
    assign out_number   = c_num_reg;

    `VRSF_ASSERT_NEXT(a_cnt_step, clk, rst_n, in_xfer,
        row_counter_reg == $past(row_counter_reg) + 32'd1, "row counter missed a transfer")
    `VRSF_ASSERT_NEXT(a_cnt_hold, clk, rst_n, !in_xfer,
        $stable(row_counter_reg), "row counter moved without a transfer")
    `VRSF_ASSERT_NOW(a_bubble_ready, clk, rst_n, !a_valid_reg || !b_valid_reg || !c_valid_reg,
        in_ready, "input stalled with a bubble in the pipe")
    `VRSF_ASSERT_NEXT(a_b_hold, clk, rst_n, b_valid_reg && !c_adv,
        b_valid_reg && $stable(b_num_reg), "stage B lost its row while stalled")

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

    localparam int MAP_IDS     = 32;
    localparam int HOLD_CYCLES = 48;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_PHASES = 14;
    localparam int PHASE_ROWS  = 100;

    // Predicts the pass flag and row index of every accepted row.
    class row_filter_scoreboard;
        logic [vrsf_pkg::MODE_W-1:0] mode;
        logic [31:0]       ant_map;
        logic [31:0]       field_map;
        logic [31:0]       dd_map;
        logic [31:0]       scan_map;
        logic [31:0]       state_map;
        logic [63:0]       time_win;
        logic [63:0]       uv_win;
        logic [31:0]       next_row;
        logic              selected_q[$];
        logic [31:0]       row_q[$];
        int                errors;

        function new();
            mode      = '0;
            ant_map   = '0;
            field_map = '0;
            dd_map    = '0;
            scan_map  = '0;
            state_map = '0;
            time_win  = '0;
            uv_win    = '0;
            next_row  = '0;
            errors    = 0;
        endfunction

        function void set_reg(logic [vrsf_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
            case (idx)
                vrsf_pkg::REG_MODE:     mode      = val[vrsf_pkg::MODE_W-1:0];
                vrsf_pkg::REG_ANTENNA:  ant_map   = val[31:0];
                vrsf_pkg::REG_FIELD:    field_map = val[31:0];
                vrsf_pkg::REG_DATADESC: dd_map    = val[31:0];
                vrsf_pkg::REG_SCAN:     scan_map  = val[31:0];
                vrsf_pkg::REG_STATE:    state_map = val[31:0];
                vrsf_pkg::REG_TIME:     time_win  = val;
                vrsf_pkg::REG_UV:       uv_win    = val;
                default:      ;
            endcase
        endfunction

        function bit id_listed(logic [31:0] map, logic [7:0] id);
            if (id >= MAP_IDS)
                return 1'b0;
            return map[id[4:0]];
        endfunction

        function bit in_window(logic [1:0] wmode, logic [63:0] val, logic [63:0] lo,
                               logic [63:0] hi);
            case (wmode)
                vrsf_pkg::WIN_GREATER: return val > lo;
                vrsf_pkg::WIN_LESS:    return val < hi;
                vrsf_pkg::WIN_RANGE:   return (val >= lo) && (val <= hi);
                default:     return 1'b1;
            endcase
        endfunction

        function logic [63:0] uv_dist_sq(logic signed [vrsf_pkg::COORD_W-1:0] u,
                                         logic signed [vrsf_pkg::COORD_W-1:0] v);
            logic [63:0] um;
            logic [63:0] vm;
            um = {40'd0, (u[vrsf_pkg::COORD_W-1] ? 24'(-u) : 24'(u))};
            vm = {40'd0, (v[vrsf_pkg::COORD_W-1] ? 24'(-v) : 24'(v))};
            return um * um + vm * vm;
        endfunction

        function void note_row(vrsf_pkg::row_t r);
            logic        pass;
            logic        hit;
            logic [63:0] lo;
            logic [63:0] hi;
            pass = 1'b1;
            if (mode[1:0] == vrsf_pkg::ANT_LIST || mode[1:0] == vrsf_pkg::ANT_NEGATED)
            begin
                hit = id_listed(ant_map, r.antenna_first) || id_listed(ant_map, r.antenna_second);
                if (mode[1:0] == vrsf_pkg::ANT_NEGATED)
                    hit = !hit;
                if (!hit)
                    pass = 1'b0;
            end
            else if (mode[1:0] == vrsf_pkg::ANT_BASELINE)
            begin
                hit = ({8'd0, r.antenna_first} == ant_map[15:0]
                       && {8'd0, r.antenna_second} == ant_map[31:16])
                   || ({8'd0, r.antenna_first} == ant_map[31:16]
                       && {8'd0, r.antenna_second} == ant_map[15:0]);
                if (!hit)
                    pass = 1'b0;
            end
            if (mode[vrsf_pkg::MODE_FIELD] && !id_listed(field_map, r.field_number))
                pass = 1'b0;
            if (mode[vrsf_pkg::MODE_DATADESC] && !id_listed(dd_map, r.datadesc_number))
                pass = 1'b0;
            if (mode[vrsf_pkg::MODE_SCAN])
            begin
                hit = id_listed(scan_map, r.scan_index);
                if (mode[vrsf_pkg::MODE_SCAN_NEG])
                    hit = !hit;
                if (!hit)
                    pass = 1'b0;
            end
            if (mode[vrsf_pkg::MODE_STATE] && !id_listed(state_map, r.state_number))
                pass = 1'b0;
            if (!in_window(mode[vrsf_pkg::MODE_TIME_LSB +: 2], {32'd0, r.row_time},
                           {32'd0, time_win[31:0]}, {32'd0, time_win[63:32]}))
                pass = 1'b0;
            lo = {32'd0, uv_win[31:0]};
            hi = {32'd0, uv_win[63:32]};
            if (!in_window(mode[vrsf_pkg::MODE_UV_LSB +: 2], uv_dist_sq(r.u_coord, r.v_coord),
                           lo * lo, hi * hi))
                pass = 1'b0;
            selected_q = {selected_q, pass};
            row_q = {row_q, next_row};
            next_row = next_row + 32'd1;
        endfunction

        function void check_result(logic selected, logic [31:0] row);
            logic        exp_sel;
            logic [31:0] exp_row;
            if (row_q.size() == 0)
            begin
                $error("unexpected result transfer: row_number %0d", row);
                errors++;
                return;
            end
            exp_sel = selected_q.pop_front();
            exp_row = row_q.pop_front();
            if (selected !== exp_sel)
            begin
                $error("row_selected: expected %0d, actual %0d", exp_sel, selected);
                errors++;
            end
            if (row !== exp_row)
            begin
                $error("row_number: expected %0d, actual %0d", exp_row, row);
                errors++;
            end
        endfunction

        function int pending();
            return row_q.size();
        endfunction
    endclass

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [vrsf_pkg::TDATA_IN_W-1:0] s_tdata   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [vrsf_pkg::ROW_W-1:0]      m_tdata;
    logic                            m_tuser;
    logic                            cfg_we    = 1'b0;
    logic [vrsf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [vrsf_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    bit tx_idle  = 1'b0;
    bit rx_idle  = 1'b0;
    bit hold_req = 1'b0;

    row_filter_scoreboard rows_sb;

    always #2 clk = ~clk;

    visibility_row_selection_filter u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            rows_sb.note_row(vrsf_pkg::row_t'(s_tdata));
        if (rst_n && m_tvalid && m_tready)
            rows_sb.check_result(m_tuser, m_tdata);
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                m_tready <= 1'b1;
            end
            else if (rx_idle && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic put_reg(input logic [vrsf_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        rows_sb.set_reg(idx, val);
    endtask

    task automatic load_regs(input logic [63:0] mode_v, input logic [63:0] ant_v,
                             input logic [63:0] fld_v, input logic [63:0] dd_v,
                             input logic [63:0] scan_v, input logic [63:0] st_v,
                             input logic [63:0] time_v, input logic [63:0] uv_v);
        put_reg(vrsf_pkg::REG_MODE, mode_v);
        put_reg(vrsf_pkg::REG_ANTENNA, ant_v);
        put_reg(vrsf_pkg::REG_FIELD, fld_v);
        put_reg(vrsf_pkg::REG_DATADESC, dd_v);
        put_reg(vrsf_pkg::REG_SCAN, scan_v);
        put_reg(vrsf_pkg::REG_STATE, st_v);
        put_reg(vrsf_pkg::REG_TIME, time_v);
        put_reg(vrsf_pkg::REG_UV, uv_v);
        cfg_we <= 1'b0;
    endtask

    // Offer one row and hold it until the transfer happens.
    task automatic send_row(input vrsf_pkg::row_t r);
        if (tx_idle && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= r;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Drop valid and wait until every row has come out.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (rows_sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic vrsf_pkg::row_t mk_row(input logic [7:0] a1, input logic [7:0] a2,
                                              input logic [7:0] fld, input logic [7:0] dd,
                                              input logic [7:0] scan, input logic [7:0] st,
                                              input logic [31:0] t, input int u, input int v);
        vrsf_pkg::row_t r;
        r.antenna_first   = a1;
        r.antenna_second  = a2;
        r.field_number    = fld;
        r.datadesc_number = dd;
        r.scan_index      = scan;
        r.state_number    = st;
        r.row_time        = t;
        r.u_coord         = u[23:0];
        r.v_coord         = v[23:0];
        return r;
    endfunction

    function automatic logic [63:0] mode_word(input logic [1:0] ant, input bit fld_en,
                                              input bit dd_en, input bit scan_en,
                                              input bit scan_neg, input bit st_en,
                                              input logic [1:0] tmode,
                                              input logic [1:0] uvmode);
        return {53'd0, uvmode, tmode, st_en, scan_neg, scan_en, dd_en, fld_en, ant};
    endfunction

    // Favor IDs whose bit is set so that rows get past the bitmap tests.
    function automatic logic [7:0] pick_id(input logic [31:0] map);
        logic [7:0] id;
        case ($urandom_range(0, 3))
            0: id = 8'($urandom_range(0, 255));
            1: id = 8'($urandom_range(0, 40));
            default:
            begin
                id = 8'($urandom_range(0, 31));
                repeat (8)
                    if (!map[id[4:0]])
                        id = 8'($urandom_range(0, 31));
            end
        endcase
        return id;
    endfunction

    function automatic logic [31:0] pick_time(input logic [31:0] lo, input logic [31:0] hi);
        logic [63:0] span;
        span = {32'd0, hi} - {32'd0, lo} + 64'd1;
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return lo + 32'($urandom_range(0, 2)) - 32'd1;
            2: return hi + 32'($urandom_range(0, 2)) - 32'd1;
            default:
                if (hi >= lo)
                    return lo + 32'({32'd0, $urandom} % span);
                else
                    return $urandom;
        endcase
    endfunction

    function automatic int pick_coord(input logic [31:0] bound);
        int b;
        int c;
        b = (bound > 32'd8388607) ? 8388607 : int'(bound);
        case ($urandom_range(0, 4))
            0: c = int'($urandom);
            1: c = b + int'($urandom_range(0, 2)) - 1;
            2: c = int'($urandom_range(0, 64)) - 32;
            3: c = $urandom_range(0, 1) ? 8388607 : -8388608;
            default: c = int'($urandom_range(0, 32'(b)));
        endcase
        if ($urandom_range(0, 1))
            c = -c;
        return c;
    endfunction

    function automatic vrsf_pkg::row_t gen_row();
        logic [7:0]  a1;
        logic [7:0]  a2;
        logic [31:0] uv_b;
        a1 = pick_id(rows_sb.ant_map);
        a2 = pick_id(rows_sb.ant_map);
        if (rows_sb.mode[1:0] == vrsf_pkg::ANT_BASELINE && $urandom_range(0, 1))
        begin
            a1 = rows_sb.ant_map[7:0];
            a2 = rows_sb.ant_map[23:16];
            if ($urandom_range(0, 1))
            begin
                a1 = rows_sb.ant_map[23:16];
                a2 = rows_sb.ant_map[7:0];
            end
        end
        uv_b = $urandom_range(0, 1) ? rows_sb.uv_win[31:0] : rows_sb.uv_win[63:32];
        return mk_row(a1, a2, pick_id(rows_sb.field_map), pick_id(rows_sb.dd_map),
                      pick_id(rows_sb.scan_map), pick_id(rows_sb.state_map),
                      pick_time(rows_sb.time_win[31:0], rows_sb.time_win[63:32]),
                      pick_coord(uv_b), $urandom_range(0, 1) ? 0 : pick_coord(uv_b));
    endfunction

    function automatic logic [63:0] rand_map();
        logic [31:0] m;
        case ($urandom_range(0, 7))
            0: m = 32'd0;
            1: m = 32'hFFFF_FFFF;
            2: m = $urandom & $urandom;
            default: m = $urandom | ($urandom & $urandom);
        endcase
        return {$urandom, m};
    endfunction

    task automatic random_setup();
        logic [63:0] mode_v;
        logic [63:0] ant_v;
        logic [31:0] t_lo;
        logic [31:0] t_hi;
        logic [31:0] uv_lo;
        logic [31:0] uv_hi;
        mode_v = {$urandom, $urandom};
        if ($urandom_range(0, 1))
            mode_v[vrsf_pkg::MODE_W-1:0] = 11'($urandom & $urandom);
        case ($urandom_range(0, 9))
            0: mode_v = 64'h7FF;
            1: mode_v = 64'd0;
            default: ;
        endcase
        ant_v = rand_map();
        if (mode_v[1:0] == vrsf_pkg::ANT_BASELINE)
        begin
            ant_v[15:0]  = 16'($urandom_range(0, 40));
            ant_v[31:16] = $urandom_range(0, 5) == 0 ? 16'($urandom_range(256, 65535))
                                                     : 16'($urandom_range(0, 40));
        end
        t_lo = $urandom;
        t_hi = t_lo + 32'($urandom_range(0, 100000));
        case ($urandom_range(0, 7))
            0:
            begin
                t_lo = 32'd0;
                t_hi = 32'hFFFF_FFFF;
            end
            1: t_hi = t_lo - 32'($urandom_range(1, 1000));
            default: ;
        endcase
        uv_lo = 32'($urandom_range(0, 6000000));
        uv_hi = uv_lo + 32'($urandom_range(0, 6000000));
        case ($urandom_range(0, 7))
            0:
            begin
                uv_lo = 32'd0;
                uv_hi = 32'hFFFF_FFFF;
            end
            1: uv_hi = uv_lo - 32'($urandom_range(1, 1000));
            2: uv_lo = 32'hFFFF_FFFF;
            default: ;
        endcase
        load_regs(mode_v, ant_v, rand_map(), rand_map(), rand_map(), rand_map(),
                  {t_hi, t_lo}, {uv_hi, uv_lo});
    endtask

    initial
    begin
        rows_sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        tx_idle = 1'b1;
        rx_idle = 1'b1;

        // registers at their reset values: every row passes
        send_row(mk_row(0, 0, 0, 0, 0, 0, 32'd0, 0, 0));
        send_row(mk_row(255, 255, 255, 255, 255, 255, 32'hFFFF_FFFF, 8388607, 8388607));
        send_row(mk_row(128, 1, 64, 2, 32, 4, 32'h8000_0000, -8388608, -8388608));
        settle();

        // all bitmaps, closed windows; junk above the register widths
        load_regs(64'hFFFF_FFFF_FFFF_F800 | mode_word(vrsf_pkg::ANT_LIST, 1, 1, 1, 0, 1,
                                                      vrsf_pkg::WIN_RANGE,
                                                      vrsf_pkg::WIN_RANGE),
                  64'hFFFF_FFFF_8000_0001, 64'h1234_5678_8000_0001, 64'hFFFF_FFFF_FFFF_FFFF,
                  64'h0000_0001_8000_0001, 64'h8000_0000_8000_0001,
                  {32'd2000, 32'd1000}, {32'd5000, 32'd100});
        send_row(mk_row(0, 5, 31, 7, 0, 31, 32'd1000, 100, 0));
        send_row(mk_row(31, 0, 0, 31, 31, 0, 32'd2000, -5000, 0));
        send_row(mk_row(0, 5, 31, 7, 0, 31, 32'd999, 100, 0));
        send_row(mk_row(0, 5, 31, 7, 0, 31, 32'd2001, 100, 0));
        send_row(mk_row(0, 5, 31, 7, 0, 31, 32'd1000, 99, 0));
        send_row(mk_row(0, 5, 31, 7, 0, 31, 32'd1000, 0, -5001));
        send_row(mk_row(0, 5, 32, 7, 0, 31, 32'd1000, 100, 0));
        send_row(mk_row(0, 5, 31, 255, 0, 32, 32'd1000, 100, 0));
        send_row(mk_row(32, 31, 31, 7, 31, 0, 32'd1500, 3000, 4000));
        send_row(mk_row(1, 2, 31, 7, 0, 31, 32'd1000, 100, 0));
        send_row(mk_row(0, 5, 31, 7, 255, 31, 32'd1000, 100, 0));
        settle();

        // negated antenna list, negated scan, open windows
        load_regs(mode_word(vrsf_pkg::ANT_NEGATED, 0, 0, 1, 1, 0, vrsf_pkg::WIN_GREATER,
                            vrsf_pkg::WIN_LESS),
                  64'h3, 64'd0, 64'd0, 64'hF0, 64'd0,
                  {32'hFFFF_FFFF, 32'd500}, {32'd300, 32'd0});
        send_row(mk_row(40, 200, 0, 0, 200, 0, 32'd501, 299, 0));
        send_row(mk_row(1, 40, 0, 0, 200, 0, 32'd501, 0, 0));
        send_row(mk_row(40, 200, 0, 0, 4, 0, 32'd501, 0, 0));
        send_row(mk_row(40, 200, 0, 0, 3, 0, 32'd500, 0, 0));
        send_row(mk_row(40, 200, 0, 0, 3, 0, 32'hFFFF_FFFF, 0, -300));
        settle();

        // baseline pair in either order; scan negate alone does nothing
        load_regs(mode_word(vrsf_pkg::ANT_BASELINE, 0, 0, 0, 1, 0, vrsf_pkg::WIN_LESS,
                            vrsf_pkg::WIN_GREATER),
                  {32'd0, 16'd200, 16'd3}, 64'd0, 64'd0, 64'd0, 64'd0,
                  {32'd10, 32'd0}, {32'd0, 32'd0});
        send_row(mk_row(3, 200, 0, 0, 0, 0, 32'd9, 1, 0));
        send_row(mk_row(200, 3, 0, 0, 9, 0, 32'd0, 0, -1));
        send_row(mk_row(3, 3, 0, 0, 0, 0, 32'd9, 1, 0));
        send_row(mk_row(3, 200, 0, 0, 0, 0, 32'd10, 1, 0));
        send_row(mk_row(3, 200, 0, 0, 0, 0, 32'd9, 0, 0));
        settle();

        // every enable; stored ID above 255; inverted time range; widest uv range
        load_regs(64'h7FF, {32'd0, 16'd300, 16'd44}, 64'hFFFF_FFFF, 64'hFFFF_FFFF,
                  64'hFFFF_FFFF, 64'hFFFF_FFFF, {32'd50, 32'd100}, {32'hFFFF_FFFF, 32'd0});
        send_row(mk_row(44, 44, 1, 1, 40, 1, 32'd75, -8388608, -8388608));
        send_row(mk_row(44, 0, 0, 0, 40, 0, 32'd100, 0, 0));
        settle();

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            tx_idle = (p < RAND_PHASES - 2) && (p % 4 != 3);
            rx_idle = tx_idle;
            random_setup();
            if (p == 2)
                hold_req = 1'b1;
            repeat (PHASE_ROWS) send_row(gen_row());
            settle();
        end

        if (rows_sb.errors == 0 && rows_sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
